[sv/trc_pkg.sv]
// package for the trusted range checker: command and status codes, cell controls
// and controller states; no dependencies
package trc_pkg;

   // widths that cover every legal table and cache depth
   localparam int LEN_BITS  = 11;
   localparam int SLOT_BITS = 10;

   typedef enum logic [2:0] {
      CMD_LOOKUP     = 3'd0,
      CMD_REPLACE    = 3'd1,
      CMD_ADD        = 3'd2,
      CMD_REMOVE     = 3'd3,
      CMD_INVALIDATE = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_INVALID = 2'd1,
      STS_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RNG_HOLD,
      RNG_KEEP,
      RNG_DROP,
      RNG_LOAD
   } rng_mode_type;

   typedef struct packed {
      rng_mode_type              mode;
      logic [LEN_BITS-1:0]       len;
   } rng_ctrl_type;

   typedef enum logic [1:0] {
      MEMO_HOLD,
      MEMO_ROTATE,
      MEMO_LOAD,
      MEMO_CLEAR
   } memo_mode_type;

   typedef struct packed {
      memo_mode_type             mode;
      logic [SLOT_BITS-1:0]      slot;
   } memo_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MEMO,
      ST_RANGE,
      ST_FILL,
      ST_COUNT,
      ST_DROP,
      ST_DONE
   } state_type;

endpackage

[sv/trc_range_cell.sv]
// one entry of the range table chain: start, end and owner of one range
// depends on trc_pkg
module trc_range_cell #(
   parameter int IDX = 0,
   parameter int DW  = 192
) (
   input  logic                  clock,
   input  trc_pkg::rng_ctrl_type ctrl,
   input  logic [DW-1:0]         next_data,
   input  logic [DW-1:0]         head_data,
   input  logic [DW-1:0]         load_data,
   output logic [DW-1:0]         data
);

   localparam int LB = trc_pkg::LEN_BITS;
   localparam logic [LB-1:0] POS  = LB'(IDX);
   localparam logic [LB-1:0] POS1 = LB'(IDX + 1);

   logic [DW-1:0] data_ff;
   logic [DW-1:0] data_in;

   // the used prefix works as a queue: head leaves at cell 0, tail enters at len-1
   always_comb begin
      data_in = data_ff;
      case (ctrl.mode)
         trc_pkg::RNG_KEEP: begin
            if (POS1 < ctrl.len) begin
               data_in = next_data;
            end else if (POS1 == ctrl.len) begin
               data_in = head_data;
            end
         end
         trc_pkg::RNG_DROP: begin
            if (POS1 < ctrl.len) begin
               data_in = next_data;
            end
         end
         trc_pkg::RNG_LOAD: begin
            if (POS == ctrl.len) begin
               data_in = load_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[sv/trc_memo_cell.sv]
// one slot of the memo ring: address, answer and valid flag
// depends on trc_pkg
module trc_memo_cell #(
   parameter int IDX = 0,
   parameter int DW  = 65
) (
   input  logic                   clock,
   input  logic                   reset,
   input  trc_pkg::memo_ctrl_type ctrl,
   input  logic                   next_valid,
   input  logic [DW-1:0]          next_data,
   input  logic [DW-1:0]          load_data,
   output logic                   valid,
   output logic [DW-1:0]          data
);

   localparam int SB = trc_pkg::SLOT_BITS;
   localparam logic [SB-1:0] POS = SB'(IDX);

   logic          valid_ff;
   logic          valid_in;
   logic [DW-1:0] data_ff;
   logic [DW-1:0] data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      case (ctrl.mode)
         trc_pkg::MEMO_ROTATE: begin
            valid_in = next_valid;
            data_in  = next_data;
         end
         trc_pkg::MEMO_LOAD: begin
            if (POS == ctrl.slot) begin
               valid_in = 1'b1;
               data_in  = load_data;
            end
         end
         trc_pkg::MEMO_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

[sv/trusted_range_check_with_cache_top.sv]
// top level of the trusted range checker: controller, range chain and memo ring
// depends on trc_pkg, trc_range_cell and trc_memo_cell
//
// usage:
//   req channel carries one command item: tuser holds the command, tdata the
//   address, image tag, range count and range bounds. rsp channel returns one
//   item per command with trusted, cache_hit, status and generation.
//   an item is taken only while the controller is idle; the result sits in an
//   output register so the next command is taken while it waits.
//   commands without a table walk pass the exec and done states before the
//   result is registered. a lookup rotates the whole memo ring, on a miss
//   also the used range prefix, then a fill state writes the memo slot.
//   a replace walks the used ranges to count them, then, if the new ranges
//   fit, once more to compact them; remove walks them once. the controller
//   is back to idle, ready for the next item, as the result is loaded. the
//   cell chains rotate one entry per cycle. reset clears counters (the
//   generation restarts at 1), pending state and memo valid flags; the range
//   table needs no clearing. when the receiver stalls the result holds and
//   the controller waits with its finished item.
module trusted_range_check_with_cache_top #(
   parameter int RANGE_ENTRIES = 128,
   parameter int CACHE_ENTRIES = 128,
   parameter int ADDRESS_BITS  = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // address[63:0], image_tag[127:64], new_range_count[135:128],
   // range_start[199:136], range_end[263:200]
   input  logic [263:0] req_tdata,
   // cmd[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // trusted[0], cache_hit[1], status[3:2], generation[67:4], zero[71:68]
   output logic [71:0]  rsp_tdata
);

   localparam int AW   = ADDRESS_BITS;
   localparam int RDW  = 2 * AW + 64;
   localparam int MDW  = AW + 1;
   localparam int RW   = $clog2(RANGE_ENTRIES + 1);
   localparam int MAXN = (RANGE_ENTRIES > CACHE_ENTRIES) ? RANGE_ENTRIES : CACHE_ENTRIES;
   localparam int SW   = $clog2(MAXN + 1);
   localparam int MW   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int LB   = trc_pkg::LEN_BITS;
   localparam int SB   = trc_pkg::SLOT_BITS;

   trc_pkg::state_type state_ff, state_in;

   logic [2:0]    cmd_ff, cmd_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [63:0]   tag_ff, tag_in;
   logic [7:0]    cnt_ff, cnt_in;
   logic [AW-1:0] rs_ff, rs_in;
   logic [AW-1:0] re_ff, re_in;
   logic [SW-1:0] step_ff, step_in;
   logic [RW-1:0] len_ff, len_in;
   logic [RW-1:0] kept_ff, kept_in;
   logic          found_ff, found_in;
   logic          ans_ff, ans_in;
   logic          hit_ff, hit_in;
   logic [1:0]    status_ff, status_in;
   logic [RW-1:0] used_ff, used_in;
   logic [63:0]   pend_owner_ff, pend_owner_in;
   logic [7:0]    pend_left_ff, pend_left_in;
   logic [MW-1:0] memo_next_ff, memo_next_in;
   logic [63:0]   gen_ff, gen_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [71:0]   rsp_data_ff, rsp_data_in;

   trc_pkg::rng_ctrl_type  rng_ctrl;
   trc_pkg::memo_ctrl_type memo_ctrl;

   logic [RDW-1:0] rng_data [RANGE_ENTRIES];
   logic [MDW-1:0] memo_data [CACHE_ENTRIES];
   logic           memo_valid [CACHE_ENTRIES];

   logic [AW-1:0] head_lo, head_hi, memo_addr;
   logic [63:0]   head_owner;
   logic          memo_match, range_match, owner_match;
   logic          step_at_used, memo_last, add_ok, over_cap, out_free;

   assign head_lo     = rng_data[0][AW-1:0];
   assign head_hi     = rng_data[0][2*AW-1:AW];
   assign head_owner  = rng_data[0][RDW-1:2*AW];
   assign memo_addr   = memo_data[0][AW-1:0];
   assign memo_match  = memo_valid[0] && (memo_addr == addr_ff);
   assign range_match = (addr_ff >= head_lo) && (addr_ff < head_hi);
   assign owner_match = (head_owner == tag_ff);
   assign step_at_used = (step_ff == SW'(used_ff));
   assign memo_last   = (step_ff == SW'(CACHE_ENTRIES - 1));
   assign add_ok      = (pend_left_ff != 8'd0) && (rs_ff < re_ff)
                        && (used_ff < RW'(RANGE_ENTRIES));
   assign over_cap    = 16'(cnt_ff) > (16'(RANGE_ENTRIES) - 16'(kept_ff));
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // range chain
   for (genvar g = 0; g < RANGE_ENTRIES; g++) begin : g_rng
      trc_range_cell #(
         .IDX (g),
         .DW  (RDW)
      ) u_cell (
         .clock     (clock),
         .ctrl      (rng_ctrl),
         .next_data (rng_data[(g + 1) % RANGE_ENTRIES]),
         .head_data (rng_data[0]),
         .load_data ({pend_owner_ff, re_ff, rs_ff}),
         .data      (rng_data[g])
      );
   end

   // memo ring
   for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_memo
      trc_memo_cell #(
         .IDX (g),
         .DW  (MDW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (memo_ctrl),
         .next_valid (memo_valid[(g + 1) % CACHE_ENTRIES]),
         .next_data  (memo_data[(g + 1) % CACHE_ENTRIES]),
         .load_data  ({ans_ff, addr_ff}),
         .valid      (memo_valid[g]),
         .data       (memo_data[g])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = trc_pkg::ST_EXEC;
            end
         end
         trc_pkg::ST_EXEC: begin
            case (cmd_ff)
               trc_pkg::CMD_LOOKUP: begin
                  state_in = (addr_ff == '0) ? trc_pkg::ST_DONE : trc_pkg::ST_MEMO;
               end
               trc_pkg::CMD_REPLACE: begin
                  state_in = (tag_ff == 64'd0) ? trc_pkg::ST_DONE : trc_pkg::ST_COUNT;
               end
               trc_pkg::CMD_REMOVE: begin
                  state_in = (tag_ff == 64'd0) ? trc_pkg::ST_DONE : trc_pkg::ST_DROP;
               end
               default: begin
                  state_in = trc_pkg::ST_DONE;
               end
            endcase
         end
         trc_pkg::ST_MEMO: begin
            if (memo_last) begin
               state_in = (found_ff || memo_match) ? trc_pkg::ST_DONE : trc_pkg::ST_RANGE;
            end
         end
         trc_pkg::ST_RANGE: begin
            if (step_at_used) begin
               state_in = trc_pkg::ST_FILL;
            end
         end
         trc_pkg::ST_FILL: begin
            state_in = trc_pkg::ST_DONE;
         end
         trc_pkg::ST_COUNT: begin
            if (step_at_used) begin
               state_in = over_cap ? trc_pkg::ST_DONE : trc_pkg::ST_DROP;
            end
         end
         trc_pkg::ST_DROP: begin
            if (step_at_used) begin
               state_in = trc_pkg::ST_DONE;
            end
         end
         trc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = trc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = trc_pkg::ST_IDLE;
         end
      endcase
   end

   // cell controls and handshake
   always_comb begin
      req_tready     = (state_ff == trc_pkg::ST_IDLE);
      rng_ctrl.mode  = trc_pkg::RNG_HOLD;
      rng_ctrl.len   = LB'(used_ff);
      memo_ctrl.mode = trc_pkg::MEMO_HOLD;
      memo_ctrl.slot = SB'(memo_next_ff);
      case (state_ff)
         trc_pkg::ST_EXEC: begin
            case (cmd_ff)
               trc_pkg::CMD_ADD: begin
                  if (add_ok) begin
                     rng_ctrl.mode  = trc_pkg::RNG_LOAD;
                     memo_ctrl.mode = trc_pkg::MEMO_CLEAR;
                  end
               end
               trc_pkg::CMD_REMOVE: begin
                  if (tag_ff == 64'd0) begin
                     memo_ctrl.mode = trc_pkg::MEMO_CLEAR;
                  end
               end
               trc_pkg::CMD_INVALIDATE: begin
                  memo_ctrl.mode = trc_pkg::MEMO_CLEAR;
               end
               default: begin
                  rng_ctrl.mode = trc_pkg::RNG_HOLD;
               end
            endcase
         end
         trc_pkg::ST_MEMO: begin
            memo_ctrl.mode = trc_pkg::MEMO_ROTATE;
         end
         trc_pkg::ST_RANGE, trc_pkg::ST_COUNT: begin
            if (!step_at_used) begin
               rng_ctrl.mode = trc_pkg::RNG_KEEP;
            end
         end
         trc_pkg::ST_FILL: begin
            memo_ctrl.mode = trc_pkg::MEMO_LOAD;
         end
         trc_pkg::ST_DROP: begin
            rng_ctrl.len = LB'(len_ff);
            if (!step_at_used) begin
               rng_ctrl.mode = owner_match ? trc_pkg::RNG_DROP : trc_pkg::RNG_KEEP;
            end else begin
               memo_ctrl.mode = trc_pkg::MEMO_CLEAR;
            end
         end
         default: begin
            rng_ctrl.mode = trc_pkg::RNG_HOLD;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      logic bump;
      bump          = 1'b0;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      tag_in        = tag_ff;
      cnt_in        = cnt_ff;
      rs_in         = rs_ff;
      re_in         = re_ff;
      step_in       = step_ff;
      len_in        = len_ff;
      kept_in       = kept_ff;
      found_in      = found_ff;
      ans_in        = ans_ff;
      hit_in        = hit_ff;
      status_in     = status_ff;
      used_in       = used_ff;
      pend_owner_in = pend_owner_ff;
      pend_left_in  = pend_left_ff;
      memo_next_in  = memo_next_ff;
      gen_in        = gen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         trc_pkg::ST_IDLE: begin
            cmd_in  = req_tuser;
            addr_in = req_tdata[AW-1:0];
            tag_in  = req_tdata[127:64];
            cnt_in  = req_tdata[135:128];
            rs_in   = req_tdata[136 +: AW];
            re_in   = req_tdata[200 +: AW];
         end
         trc_pkg::ST_EXEC: begin
            step_in   = '0;
            kept_in   = '0;
            len_in    = used_ff;
            found_in  = 1'b0;
            ans_in    = 1'b0;
            hit_in    = 1'b0;
            status_in = trc_pkg::STS_OK;
            case (cmd_ff)
               trc_pkg::CMD_LOOKUP: begin
                  status_in = trc_pkg::STS_OK;
               end
               trc_pkg::CMD_REPLACE: begin
                  if (tag_ff == 64'd0) begin
                     status_in = trc_pkg::STS_INVALID;
                  end
               end
               trc_pkg::CMD_ADD: begin
                  if ((pend_left_ff == 8'd0) || (rs_ff >= re_ff)) begin
                     status_in = trc_pkg::STS_INVALID;
                  end else if (used_ff >= RW'(RANGE_ENTRIES)) begin
                     status_in = trc_pkg::STS_FULL;
                  end else begin
                     used_in      = used_ff + 1'b1;
                     pend_left_in = pend_left_ff - 8'd1;
                     bump         = 1'b1;
                  end
               end
               trc_pkg::CMD_REMOVE: begin
                  if (tag_ff == 64'd0) begin
                     status_in = trc_pkg::STS_INVALID;
                     bump      = 1'b1;
                  end
               end
               trc_pkg::CMD_INVALIDATE: begin
                  bump = 1'b1;
               end
               default: begin
                  status_in = trc_pkg::STS_INVALID;
               end
            endcase
         end
         trc_pkg::ST_MEMO: begin
            if (memo_match) begin
               found_in = 1'b1;
               ans_in   = memo_data[0][AW];
            end
            step_in = step_ff + 1'b1;
            if (memo_last) begin
               step_in = '0;
               hit_in  = found_ff || memo_match;
            end
         end
         trc_pkg::ST_RANGE: begin
            if (!step_at_used) begin
               if (range_match) begin
                  ans_in = 1'b1;
               end
               step_in = step_ff + 1'b1;
            end
         end
         trc_pkg::ST_FILL: begin
            memo_next_in = (memo_next_ff == MW'(CACHE_ENTRIES - 1)) ? '0
                           : memo_next_ff + 1'b1;
         end
         trc_pkg::ST_COUNT: begin
            if (!step_at_used) begin
               if (!owner_match) begin
                  kept_in = kept_ff + 1'b1;
               end
               step_in = step_ff + 1'b1;
            end else if (over_cap) begin
               status_in = trc_pkg::STS_FULL;
            end else begin
               step_in = '0;
               len_in  = used_ff;
            end
         end
         trc_pkg::ST_DROP: begin
            if (!step_at_used) begin
               if (owner_match) begin
                  len_in = len_ff - 1'b1;
               end
               step_in = step_ff + 1'b1;
            end else begin
               used_in = len_ff;
               if (cmd_ff == trc_pkg::CMD_REPLACE) begin
                  pend_owner_in = tag_ff;
                  pend_left_in  = cnt_ff;
               end else if (pend_owner_ff == tag_ff) begin
                  pend_left_in = 8'd0;
               end
               bump = 1'b1;
            end
         end
         trc_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, gen_ff, status_ff, hit_ff, ans_ff};
            end
         end
         default: begin
            step_in = step_ff;
         end
      endcase
      // generation skips zero on wrap
      if (bump) begin
         gen_in       = (gen_ff == '1) ? 64'd1 : gen_ff + 64'd1;
         memo_next_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= trc_pkg::ST_IDLE;
         used_ff       <= '0;
         pend_owner_ff <= '0;
         pend_left_ff  <= '0;
         memo_next_ff  <= '0;
         gen_ff        <= 64'd1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         pend_owner_ff <= pend_owner_in;
         pend_left_ff  <= pend_left_in;
         memo_next_ff  <= memo_next_in;
         gen_ff        <= gen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      tag_ff      <= tag_in;
      cnt_ff      <= cnt_in;
      rs_ff       <= rs_in;
      re_ff       <= re_in;
      step_ff     <= step_in;
      len_ff      <= len_in;
      kept_ff     <= kept_in;
      found_ff    <= found_in;
      ans_ff      <= ans_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sv/trc_checker.sv]
// port-level checks for the trusted range checker, bound to the top level
// depends on trusted_range_check_with_cache_top
module trc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   // generation never reads zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[67:4] != 64'd0)
      else $error("generation is zero");

   // a memo hit is always a clean lookup answer
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[3:2] == 2'd0)
      else $error("cache hit with error status");

   // trusted only ever with ok status and a zero pad
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[3:2] == 2'd0 && rsp_tdata[71:68] == 4'd0)
      else $error("trusted answer with error status");

   // nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind trusted_range_check_with_cache_top trc_checker u_trc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[sim/tb_top.sv]
// testbench for the trusted range checker: drives command items, predicts each
// result from a local copy of range table, memo cache and generation; needs trc_pkg
`timescale 1ns / 100ps

module tb_top;

   localparam int NRANGE = 128;
   localparam int NMEMO  = 128;
   localparam longint unsigned LIMIT = 1500000;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] address;
      logic [63:0] image_tag;
      logic [7:0]  new_range_count;
      logic [63:0] range_start;
      logic [63:0] range_end;
   } cmd_item_type;

   typedef struct packed {
      logic        trusted;
      logic        cache_hit;
      logic [1:0]  status;
      logic [63:0] generation;
   } verdict_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [263:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [71:0]  rsp_tdata;

   trusted_range_check_with_cache_top u_dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // predictor state
   logic [63:0] tbl_lo[NRANGE], tbl_hi[NRANGE], tbl_owner[NRANGE];
   int          tbl_used;
   logic [63:0] load_owner;
   int          load_left;
   logic [63:0] memo_addr[NMEMO];
   logic        memo_ok[NMEMO], memo_ans[NMEMO];
   int          memo_ptr;
   logic [63:0] gen;

   cmd_item_type pending_items[$];
   verdict_type  expected_verdicts[$];
   int        errors = 0;
   int        send_idle_pct = 30, recv_idle_pct = 88;
   longint unsigned cycles = 0;

   // tags used in random traffic, small set so replaces and removes collide
   logic [63:0] tag_pool[4] = '{64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0002,
                                64'h1234_5678};

   function automatic void new_generation();
      gen = gen + 1;
      if (gen == 0) gen = 1;
      for (int i = 0; i < NMEMO; i++) memo_ok[i] = 0;
      memo_ptr = 0;
   endfunction

   function automatic void drop_image(input logic [63:0] tag);
      int w;
      w = 0;
      for (int i = 0; i < tbl_used; i++) begin
         if (tbl_owner[i] != tag) begin
            tbl_lo[w] = tbl_lo[i];
            tbl_hi[w] = tbl_hi[i];
            tbl_owner[w] = tbl_owner[i];
            w++;
         end
      end
      tbl_used = w;
   endfunction

   function automatic verdict_type classify_command(input cmd_item_type it);
      verdict_type v;
      int kept;
      logic found, ans;
      v = '0;
      case (it.cmd)
         trc_pkg::CMD_LOOKUP: begin
            if (it.address != 0) begin
               found = 0;
               for (int i = 0; i < NMEMO && !found; i++) begin
                  if (memo_ok[i] && memo_addr[i] == it.address) begin
                     v.trusted = memo_ans[i];
                     v.cache_hit = 1;
                     found = 1;
                  end
               end
               if (!found) begin
                  ans = 0;
                  for (int i = 0; i < tbl_used; i++)
                     if (it.address >= tbl_lo[i] && it.address < tbl_hi[i]) ans = 1;
                  memo_addr[memo_ptr] = it.address;
                  memo_ans[memo_ptr] = ans;
                  memo_ok[memo_ptr] = 1;
                  memo_ptr = (memo_ptr + 1) % NMEMO;
                  v.trusted = ans;
               end
            end
         end
         trc_pkg::CMD_REPLACE: begin
            if (it.image_tag == 0) v.status = trc_pkg::STS_INVALID;
            else begin
               kept = 0;
               for (int i = 0; i < tbl_used; i++) if (tbl_owner[i] != it.image_tag) kept++;
               if (int'(it.new_range_count) > NRANGE - kept) v.status = trc_pkg::STS_FULL;
               else begin
                  drop_image(it.image_tag);
                  load_owner = it.image_tag;
                  load_left = int'(it.new_range_count);
                  new_generation();
               end
            end
         end
         trc_pkg::CMD_ADD: begin
            if (load_left == 0 || it.range_start >= it.range_end)
               v.status = trc_pkg::STS_INVALID;
            else if (tbl_used >= NRANGE) v.status = trc_pkg::STS_FULL;
            else begin
               tbl_lo[tbl_used] = it.range_start;
               tbl_hi[tbl_used] = it.range_end;
               tbl_owner[tbl_used] = load_owner;
               tbl_used++;
               load_left--;
               new_generation();
            end
         end
         trc_pkg::CMD_REMOVE: begin
            if (it.image_tag == 0) v.status = trc_pkg::STS_INVALID;
            else begin
               drop_image(it.image_tag);
               if (load_owner == it.image_tag) load_left = 0;
            end
            new_generation();
         end
         trc_pkg::CMD_INVALIDATE: new_generation();
         default: v.status = trc_pkg::STS_INVALID;
      endcase
      v.generation = gen;
      return v;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // address near range bounds so lookups hit edges, a small one, or fully random
   function automatic logic [63:0] pick_address();
      int k;
      k = $urandom_range(0, 9);
      if (k < 6 && tbl_used > 0) begin
         k = $urandom_range(0, tbl_used - 1);
         case ($urandom_range(0, 3))
            0: return tbl_lo[k];
            1: return tbl_hi[k];
            2: return tbl_hi[k] - 1;
            default: return tbl_lo[k] - 1;
         endcase
      end
      if (k == 9) return 64'($urandom_range(0, 3));
      return rand64();
   endfunction

   function automatic cmd_item_type make_item(input logic [2:0] c);
      cmd_item_type it;
      it.cmd = c;
      it.address = rand64();
      it.image_tag = rand64();
      it.new_range_count = 8'($urandom());
      it.range_start = rand64();
      it.range_end = rand64();
      return it;
   endfunction

   task automatic queue_item(input cmd_item_type it);
      pending_items.push_back(it);
   endtask

   // a well-formed load: replace then count adds with random content
   task automatic queue_load(input logic [63:0] tag, input int n);
      cmd_item_type it;
      logic [63:0] a, b;
      it = make_item(trc_pkg::CMD_REPLACE);
      it.image_tag = tag;
      it.new_range_count = 8'(n);
      queue_item(it);
      for (int i = 0; i < n; i++) begin
         it = make_item(trc_pkg::CMD_ADD);
         a = rand64();
         b = a + 64'($urandom_range(1, 1 << 20));
         if (b <= a) begin
            b = a;
            a = a - 5;
         end
         it.range_start = a;
         it.range_end = b;
         queue_item(it);
      end
   endtask

   task automatic queue_random(input int count);
      cmd_item_type it;
      int r;
      for (int n = 0; n < count; ) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            r = $urandom_range(0, 8);
            queue_load(tag_pool[$urandom_range(0, 3)], r);
            n += r + 1;
         end else if (r < 75) begin
            it = make_item(trc_pkg::CMD_LOOKUP);
            queue_item(it);
            n++;
         end else begin
            it = make_item(3'($urandom_range(1, 7)));
            if ($urandom_range(0, 1)) it.image_tag = tag_pool[$urandom_range(0, 3)];
            if (it.cmd == trc_pkg::CMD_REPLACE) it.new_range_count = 8'($urandom_range(0, 140));
            queue_item(it);
            n++;
         end
      end
   endtask

   // waits until every sent item has its result, then lets the block settle
   task automatic wait_drained();
      while (pending_items.size() != 0 || expected_verdicts.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (NMEMO + NRANGE + 10) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      cmd_item_type it;
      if (reset) req_tvalid <= 0;
      else if (!req_tvalid || req_tready) begin
         if (req_tvalid && req_tready) begin
            it = cmd_item_type'({req_tuser, req_tdata[63:0], req_tdata[127:64],
                                 req_tdata[135:128], req_tdata[199:136], req_tdata[263:200]});
            expected_verdicts.push_back(classify_command(it));
         end
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            it = pending_items.pop_front();
            // lookups with start bit 0 set pick a live address now
            if (it.cmd == trc_pkg::CMD_LOOKUP && it.range_start[0]) it.address = pick_address();
            req_tvalid <= 1;
            req_tuser <= it.cmd;
            req_tdata <= {it.range_end, it.range_start, it.new_range_count,
                          it.image_tag, it.address};
         end else req_tvalid <= 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      verdict_type got, exp_v;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = verdict_type'({rsp_tdata[0], rsp_tdata[1], rsp_tdata[3:2], rsp_tdata[67:4]});
            if (expected_verdicts.size() == 0) begin
               $error("unexpected result item %h", rsp_tdata);
               errors++;
            end else begin
               exp_v = expected_verdicts.pop_front();
               if (got.trusted !== exp_v.trusted) begin
                  $error("trusted: expected %0d actual %0d", exp_v.trusted, got.trusted);
                  errors++;
               end
               if (got.cache_hit !== exp_v.cache_hit) begin
                  $error("cache_hit: expected %0d actual %0d", exp_v.cache_hit, got.cache_hit);
                  errors++;
               end
               if (got.status !== exp_v.status) begin
                  $error("status: expected %0d actual %0d", exp_v.status, got.status);
                  errors++;
               end
               if (got.generation !== exp_v.generation) begin
                  $error("generation: expected %0d actual %0d", exp_v.generation,
                         got.generation);
                  errors++;
               end
               if (rsp_tdata[71:68] !== 4'b0) begin
                  $error("pad: expected 0 actual %h", rsp_tdata[71:68]);
                  errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      cmd_item_type it;
      tbl_used = 0;
      load_owner = 0;
      load_left = 0;
      memo_ptr = 0;
      gen = 1;
      for (int i = 0; i < NMEMO; i++) memo_ok[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 0;

      // directed: edge fields, every command, special cases
      it = make_item(trc_pkg::CMD_LOOKUP); it.address = 0; it.range_start = 0; queue_item(it);
      it = make_item(trc_pkg::CMD_ADD); it.range_start = 1; it.range_end = 2; queue_item(it);
      it = make_item(trc_pkg::CMD_REPLACE); it.image_tag = 0; queue_item(it);
      it = make_item(trc_pkg::CMD_REPLACE); it.image_tag = 5; it.new_range_count = 129;
      queue_item(it);
      it = make_item(trc_pkg::CMD_REPLACE); it.image_tag = '1; it.new_range_count = 128;
      queue_item(it);
      it = make_item(trc_pkg::CMD_ADD); it.range_start = '1; it.range_end = '1; queue_item(it);
      it = make_item(trc_pkg::CMD_ADD); it.range_start = 9; it.range_end = 3; queue_item(it);
      it = make_item(trc_pkg::CMD_ADD); it.range_start = 0; it.range_end = '1; queue_item(it);
      it = make_item(trc_pkg::CMD_ADD); it.range_start = 64'h10; it.range_end = 64'h20;
      queue_item(it);
      it = make_item(trc_pkg::CMD_LOOKUP); it.address = '1; it.range_start = 0; queue_item(it);
      it = make_item(trc_pkg::CMD_LOOKUP); it.address = 64'hFFFF_FFFF_FFFF_FFFE;
      it.range_start = 0;
      queue_item(it);
      it = make_item(trc_pkg::CMD_LOOKUP); it.address = 64'hFFFF_FFFF_FFFF_FFFE;
      it.range_start = 0;
      queue_item(it);
      it = make_item(trc_pkg::CMD_LOOKUP); it.address = 1; it.range_start = 0; queue_item(it);
      it = make_item(trc_pkg::CMD_REPLACE); it.image_tag = 7; it.new_range_count = 0;
      queue_item(it);
      it = make_item(trc_pkg::CMD_REMOVE); it.image_tag = 0; queue_item(it);
      it = make_item(trc_pkg::CMD_REMOVE); it.image_tag = '1; queue_item(it);
      it = make_item(trc_pkg::CMD_ADD); it.range_start = 1; it.range_end = 2; queue_item(it);
      it = make_item(trc_pkg::CMD_INVALIDATE); queue_item(it);
      for (int c = 5; c < 8; c++) begin
         it = make_item(3'(c));
         queue_item(it);
      end
      it = make_item(trc_pkg::CMD_LOOKUP); it.address = 1; it.range_start = 0; queue_item(it);
      wait_drained();

      // pause with nothing in flight, then random in three idling phases
      queue_random(320);
      wait_drained();
      send_idle_pct = 88;
      recv_idle_pct = 30;
      queue_random(320);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(310);
      wait_drained();

      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

[filelist.f]
sv/trc_pkg.sv
sv/trc_range_cell.sv
sv/trc_memo_cell.sv
sv/trusted_range_check_with_cache_top.sv
sv/trc_checker.sv
sim/tb_top.sv
